[rtl/rpr_pkg.sv]
package rpr_pkg;

   localparam int MAX_PHASES_DEF = 64;
   localparam int MAX_TAPS_DEF   = 28;
   localparam int CHANNELS_DEF   = 2;

   localparam int SHORT_TAPS = 24;
   localparam int RESULT_CAP = 64;
   localparam int FRAC_BITS  = 15;
   localparam int OUT_MAX    = 32767;
   localparam int OUT_MIN    = -32768;

   localparam int SMP_W      = 16;
   localparam int FACTOR_W   = 7;
   localparam int PHASE_W    = 8;
   localparam int TAP_W      = 5;
   localparam int IDX_W      = 13;
   localparam int CIDX_W     = 11;
   localparam int CNT_W      = 7;
   localparam int PROD_W     = 32;
   localparam int ACC_W      = 37;
   localparam int CH_SEL_W   = 3;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_UP_FACTOR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_FACTOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_FILTER = 2'd2;

   localparam logic FUNC_COEF   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN,
      ST_OUT
   } rpr_state_type;

   typedef struct packed {
      logic                shift;
      logic                rotate;
      logic                long_sel;
      logic [CH_SEL_W-1:0] ch;
   } chain_ctl_type;

   typedef struct packed {
      logic issue;
      logic clear;
   } mac_ctl_type;

endpackage

[rtl/polyphase_rational_resampler.sv]
// a coefficient item is written to the table when in range and leaves the input open;
// a sample item holds the input until its last result is loaded for output (taps = 24 or 28),
// as each result takes one multiply-accumulate per tap while the delay line rotates
// past a single MAC
// reset: synchronous, clears config to L=1 M=1 short filter, delay lines and phases;
// the coefficient table is not cleared and must be written before use
module polyphase_rational_resampler
   import rpr_pkg::*;
#(
   parameter int MAX_PHASES = MAX_PHASES_DEF,
   parameter int MAX_TAPS   = MAX_TAPS_DEF,
   parameter int CHANNELS   = CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // channel, coef_index, coef_value, sample
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_sample, out_channel
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int TABLE_SIZE = MAX_PHASES * MAX_TAPS;
   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   rpr_state_type state_ff, state_in;

   logic [FACTOR_W-1:0]     up_ff;
   logic [FACTOR_W-1:0]     down_ff;
   logic                    long_ff;
   logic [FACTOR_W-1:0]     phase_cnt_ff [CHANNELS];
   logic [CH_W-1:0]         ch_ff;
   logic [PHASE_W-1:0]      phase_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [TAP_W-1:0]        k_ff;
   logic [IDX_W-1:0]        base_ff;
   logic                    rsp_valid_ff;
   logic signed [SMP_W-1:0] rsp_sample_ff;
   logic                    rsp_ch_ff;
   logic                    rsp_last_ff;

   logic                    req_func;
   logic                    req_ch;
   logic [CIDX_W-1:0]       req_cidx;
   logic signed [SMP_W-1:0] req_coef;
   logic signed [SMP_W-1:0] req_sample;
   logic [CH_W-1:0]         req_ch_idx;
   logic                    accept;
   logic                    sample_go;
   logic                    coef_we;
   logic [TAP_W-1:0]        taps;
   logic [TAP_W-1:0]        tap_sel;
   logic [FACTOR_W-1:0]     ph_old;
   logic [PHASE_W-1:0]      phase_next;
   logic                    more;
   logic                    more_next;
   logic                    run_done;
   logic                    out_free;
   logic                    load_out;
   logic                    store_phase;
   logic                    rotate;
   chain_ctl_type           chain_ctl;
   mac_ctl_type             mac_ctl;
   logic signed [SMP_W-1:0] tail;
   logic signed [SMP_W-1:0] result;
   logic [IDX_W-1:0]        rd_idx;

   assign req_ch     = req_tdata[0];
   assign req_cidx   = req_tdata[11:1];
   assign req_coef   = req_tdata[27:12];
   assign req_sample = req_tdata[43:28];
   assign req_func   = req_tuser[0];
   assign req_ch_idx = CH_W'(req_ch);

   assign accept    = req_tvalid && req_tready;
   assign sample_go = accept && (req_func == FUNC_SAMPLE) && (32'(req_ch) < CHANNELS);
   assign coef_we   = accept && (req_func == FUNC_COEF) && (32'(req_cidx) < TABLE_SIZE);

   assign taps       = long_ff ? TAP_W'(MAX_TAPS) : TAP_W'(SHORT_TAPS);
   assign tap_sel    = taps - TAP_W'(1) - k_ff;
   assign ph_old     = phase_cnt_ff[req_ch_idx];
   assign phase_next = phase_ff + PHASE_W'(down_ff);
   assign more       = (phase_ff < PHASE_W'(up_ff)) && (cnt_ff < CNT_W'(RESULT_CAP));
   assign more_next  = (phase_next < PHASE_W'(up_ff))
                       && ((cnt_ff + CNT_W'(1)) < CNT_W'(RESULT_CAP));
   assign run_done   = k_ff == (taps + TAP_W'(1));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rd_idx     = base_ff + IDX_W'(tap_sel);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sample_go) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = more ? ST_RUN : ST_IDLE;
         end
         ST_RUN: begin
            if (run_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      rotate      = 1'b0;
      load_out    = 1'b0;
      store_phase = 1'b0;
      mac_ctl     = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_CHECK: begin
            mac_ctl.clear = 1'b1;
            store_phase   = !more;
         end
         ST_RUN: begin
            rotate        = k_ff < taps;
            mac_ctl.issue = k_ff < taps;
         end
         ST_OUT: begin
            load_out = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign chain_ctl.shift    = sample_go;
   assign chain_ctl.rotate   = rotate;
   assign chain_ctl.long_sel = long_ff;
   assign chain_ctl.ch       = sample_go ? CH_SEL_W'(req_ch_idx) : CH_SEL_W'(ch_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         up_ff        <= FACTOR_W'(1);
         down_ff      <= FACTOR_W'(1);
         long_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ch_ff        <= '0;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         k_ff         <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            phase_cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_UP_FACTOR:   up_ff   <= csr_data;
               CSR_DOWN_FACTOR: down_ff <= csr_data;
               CSR_LONG_FILTER: long_ff <= csr_data[0];
               default:         ;
            endcase
         end
         if (sample_go) begin
            ch_ff    <= req_ch_idx;
            phase_ff <= (ph_old >= up_ff) ? PHASE_W'(ph_old - up_ff) : PHASE_W'(ph_old);
            cnt_ff   <= '0;
         end else if (load_out) begin
            phase_ff <= phase_next;
            cnt_ff   <= cnt_ff + CNT_W'(1);
         end
         if (state_ff == ST_CHECK) begin
            k_ff <= '0;
         end else if (state_ff == ST_RUN) begin
            k_ff <= k_ff + TAP_W'(1);
         end
         if (store_phase) begin
            phase_cnt_ff[ch_ff] <= phase_ff[FACTOR_W-1:0];
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         base_ff <= IDX_W'(phase_ff[FACTOR_W-1:0] * taps);
      end
      if (load_out) begin
         rsp_sample_ff <= result;
         rsp_ch_ff     <= ch_ff[0];
         rsp_last_ff   <= !more_next;
      end
   end

   rpr_delay_chain #(
      .MAX_TAPS (MAX_TAPS),
      .CHANNELS (CHANNELS)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctl    (chain_ctl),
      .sample (req_sample),
      .tail   (tail)
   );

   rpr_mac #(
      .MAX_PHASES (MAX_PHASES),
      .MAX_TAPS   (MAX_TAPS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (coef_we),
      .wr_idx  (IDX_W'(req_cidx)),
      .wr_data (req_coef),
      .ctl     (mac_ctl),
      .rd_idx  (rd_idx),
      .tail    (tail),
      .result  (result)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - SMP_W - 1)'(0), rsp_ch_ff, rsp_sample_ff};

endmodule

[rtl/rpr_tap_cell.sv]
module rpr_tap_cell
   import rpr_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic [CH_SEL_W-1:0]     ch_sel,
   input  logic signed [SMP_W-1:0] din,
   output logic signed [SMP_W-1:0] dout
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic signed [SMP_W-1:0] word_ff [CHANNELS];
   logic [CH_W-1:0]         ch_idx;

   assign ch_idx = ch_sel[CH_W-1:0];
   assign dout   = word_ff[ch_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            word_ff[i] <= '0;
         end
      end else if (enable) begin
         word_ff[ch_idx] <= din;
      end
   end

endmodule

[rtl/rpr_delay_chain.sv]
module rpr_delay_chain
   import rpr_pkg::*;
#(
   parameter int MAX_TAPS = MAX_TAPS_DEF,
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  chain_ctl_type           ctl,
   input  logic signed [SMP_W-1:0] sample,
   output logic signed [SMP_W-1:0] tail
);

   logic signed [SMP_W-1:0] din  [MAX_TAPS];
   logic signed [SMP_W-1:0] dout [MAX_TAPS];
   logic [MAX_TAPS-1:0]     en;

   // tail is the oldest active tap; rotating feeds it back to the head
   assign tail = ctl.long_sel ? dout[MAX_TAPS-1] : dout[SHORT_TAPS-1];

   for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign din[i] = ctl.shift ? sample : tail;
      end else begin : g_body
         assign din[i] = dout[i-1];
      end
      assign en[i] = (ctl.shift || ctl.rotate) && (ctl.long_sel || (i < SHORT_TAPS));

      rpr_tap_cell #(
         .CHANNELS (CHANNELS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (en[i]),
         .ch_sel (ctl.ch),
         .din    (din[i]),
         .dout   (dout[i])
      );
   end

endmodule

[rtl/rpr_mac.sv]
module rpr_mac
   import rpr_pkg::*;
#(
   parameter int MAX_PHASES = MAX_PHASES_DEF,
   parameter int MAX_TAPS   = MAX_TAPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_idx,
   input  logic signed [SMP_W-1:0] wr_data,
   input  mac_ctl_type             ctl,
   input  logic [IDX_W-1:0]        rd_idx,
   input  logic signed [SMP_W-1:0] tail,
   output logic signed [SMP_W-1:0] result
);

   localparam int TABLE_SIZE = MAX_PHASES * MAX_TAPS;
   localparam int ADDR_W     = $clog2(TABLE_SIZE);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

   logic signed [SMP_W-1:0]  coef_mem [TABLE_SIZE];
   logic signed [SMP_W-1:0]  rdata_ff;
   logic signed [SMP_W-1:0]  tail_ff;
   logic                     oob_ff;
   logic                     v1_ff;
   logic                     v2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [SMP_W-1:0]  coef;
   logic signed [ACC_W-1:0]  scaled;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_mem[wr_idx[ADDR_W-1:0]] <= wr_data;
      end
      rdata_ff <= coef_mem[rd_idx[ADDR_W-1:0]];
   end

   // out-of-table phases read as zero
   assign coef = oob_ff ? '0 : rdata_ff;

   always_ff @(posedge clock) begin
      tail_ff <= tail;
      oob_ff  <= 32'(rd_idx) >= TABLE_SIZE;
      prod_ff <= tail_ff * coef;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         v1_ff <= ctl.issue;
         v2_ff <= v1_ff;
         if (ctl.clear) begin
            acc_ff <= '0;
         end else if (v2_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // floor shift then saturate
   assign scaled = acc_ff >>> FRAC_BITS;

   always_comb begin
      if (scaled > SAT_HI) begin
         result = SMP_W'(SAT_HI);
      end else if (scaled < SAT_LO) begin
         result = SMP_W'(SAT_LO);
      end else begin
         result = scaled[SMP_W-1:0];
      end
   end

endmodule

[rtl/rpr_checker.sv]
module rpr_checker
   import rpr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [0:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // a sample item on channel zero closes the input in the cycle after it is accepted
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == FUNC_SAMPLE) && !req_tdata[0]
      |=> !req_tready)
      else $error("input ready right after a sample item");

   // a coefficient item leaves the input open
   a_coef_open: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == FUNC_COEF) |=> req_tready)
      else $error("input closed after a coefficient item");

   // a new result only appears while a sample item is being worked on
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !req_tready)
      else $error("result appeared while idle");

endmodule

bind polyphase_rational_resampler rpr_checker u_rpr_checker (.*);

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
   import rpr_pkg::*;

   localparam int TABLE_WORDS  = MAX_PHASES_DEF * MAX_TAPS_DEF;
   localparam int DRAIN_CYCLES = 48;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DIR_ROWS     = 24;
   localparam int PHASES       = 8;

   typedef struct packed {
      logic        func;
      logic        ch;
      logic [10:0] idx;
      logic [15:0] val;
      logic [15:0] smp;
   } req_item_t;

   typedef struct packed {
      logic signed [15:0] smp;
      logic               ch;
      logic               last;
   } out_item_t;

   typedef struct packed {
      logic        func;
      logic        ch;
      logic [10:0] idx;
      logic [15:0] val;
      logic [15:0] smp;
      logic        chk;
      logic [15:0] exp_smp;
   } dir_row_t;

   typedef struct packed {
      logic [6:0] up;
      logic [6:0] down;
      logic [1:0] long_sel;
      logic [6:0] idle;
      logic [6:0] stall;
      logic [7:0] count;
   } phase_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   polyphase_rational_resampler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow state of the resampler
   logic signed [15:0] coef_shadow [TABLE_WORDS];
   logic signed [15:0] line_shadow [CHANNELS_DEF][MAX_TAPS_DEF];
   logic [6:0]         phase_shadow [CHANNELS_DEF];
   logic [6:0]         cfg_up = 7'd1;
   logic [6:0]         cfg_down = 7'd1;
   logic               cfg_long = 1'b0;

   out_item_t pending_outputs [$];
   out_item_t head_item;
   int        errors = 0;
   int        idle_pct = 0;
   int        stall_pct = 0;
   int        cycle_count = 0;

   dir_row_t dir_tab [DIR_ROWS] = '{
      '{FUNC_SAMPLE, 1'b0, 11'd0,    16'h0000, 16'h04d2, 1'b1, 16'h0000},
      '{FUNC_COEF,   1'b0, 11'd0,    16'h8000, 16'h0000, 1'b0, 16'h0000},
      '{FUNC_SAMPLE, 1'b0, 11'd0,    16'h0000, 16'h8000, 1'b1, 16'h7fff},
      '{FUNC_SAMPLE, 1'b1, 11'd0,    16'hffff, 16'h8000, 1'b1, 16'h7fff},
      '{FUNC_COEF,   1'b1, 11'd0,    16'h7fff, 16'hffff, 1'b0, 16'h0000},
      '{FUNC_SAMPLE, 1'b0, 11'd2047, 16'h0000, 16'h8000, 1'b1, 16'h8001},
      '{FUNC_COEF,   1'b0, 11'd1,    16'h8000, 16'h0000, 1'b0, 16'h0000},
      '{FUNC_COEF,   1'b0, 11'd2,    16'h8000, 16'h0000, 1'b0, 16'h0000},
      '{FUNC_SAMPLE, 1'b0, 11'd0,    16'h0000, 16'h7fff, 1'b1, 16'h7fff},
      '{FUNC_COEF,   1'b0, 11'd0,    16'h8000, 16'h0000, 1'b0, 16'h0000},
      '{FUNC_COEF,   1'b0, 11'd1,    16'h7fff, 16'h0000, 1'b0, 16'h0000},
      '{FUNC_COEF,   1'b0, 11'd2,    16'h7fff, 16'h0000, 1'b0, 16'h0000},
      '{FUNC_SAMPLE, 1'b0, 11'd0,    16'h0000, 16'h7fff, 1'b1, 16'h8000},
      // writes past the table are dropped
      '{FUNC_COEF,   1'b0, 11'd2047, 16'h7fff, 16'h0000, 1'b0, 16'h0000},
      '{FUNC_COEF,   1'b1, 11'd1792, 16'hffff, 16'h0000, 1'b0, 16'h0000},
      '{FUNC_COEF,   1'b0, 11'd1791, 16'hffff, 16'h0000, 1'b0, 16'h0000},
      '{FUNC_SAMPLE, 1'b1, 11'd0,    16'h0000, 16'h0001, 1'b0, 16'h0000},
      '{FUNC_COEF,   1'b0, 11'd3,    16'h0001, 16'h0000, 1'b0, 16'h0000},
      '{FUNC_SAMPLE, 1'b1, 11'd0,    16'h0000, 16'hffff, 1'b0, 16'h0000},
      '{FUNC_COEF,   1'b0, 11'd0,    16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{FUNC_COEF,   1'b0, 11'd1,    16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{FUNC_COEF,   1'b0, 11'd2,    16'h0000, 16'h0000, 1'b0, 16'h0000},
      // floor of a small negative and a small positive sum
      '{FUNC_SAMPLE, 1'b0, 11'd0,    16'h0000, 16'hffff, 1'b1, 16'hffff},
      '{FUNC_SAMPLE, 1'b0, 11'd0,    16'h0000, 16'h0000, 1'b1, 16'h0000}
   };

   // an up or down of zero picks that factor at random; a long_sel above one picks the filter at random
   phase_t phase_tab [PHASES] = '{
      '{7'd1,  7'd1,  2'd1, 7'd0,  7'd0,  8'd40},
      '{7'd3,  7'd2,  2'd0, 7'd53, 7'd0,  8'd40},
      '{7'd2,  7'd3,  2'd1, 7'd0,  7'd53, 8'd40},
      '{7'd64, 7'd64, 2'd0, 7'd23, 7'd23, 8'd30},
      '{7'd64, 7'd1,  2'd1, 7'd0,  7'd0,  8'd6},
      '{7'd1,  7'd64, 2'd0, 7'd53, 7'd0,  8'd60},
      '{7'd0,  7'd0,  2'd2, 7'd0,  7'd53, 8'd40},
      '{7'd0,  7'd0,  2'd2, 7'd23, 7'd23, 8'd40}
   };

   function automatic void resample_predict(input logic ch, input logic signed [15:0] smp);
      int        taps;
      int        ph;
      int        n;
      int        idx;
      longint    acc;
      longint    q;
      longint    c;
      out_item_t r;
      taps = cfg_long ? MAX_TAPS_DEF : SHORT_TAPS;
      ph = phase_shadow[ch];
      if (ph >= cfg_up) ph = ph - cfg_up;
      for (int t = taps - 1; t > 0; t--) line_shadow[ch][t] = line_shadow[ch][t-1];
      line_shadow[ch][0] = smp;
      n = 0;
      while (ph < cfg_up && n < RESULT_CAP) begin
         acc = 0;
         for (int t = 0; t < taps; t++) begin
            idx = ph * taps + t;
            c = (idx < TABLE_WORDS) ? longint'(coef_shadow[idx]) : 0;
            acc += longint'(line_shadow[ch][t]) * c;
         end
         q = acc >>> FRAC_BITS;
         if (q > OUT_MAX) q = OUT_MAX;
         else if (q < OUT_MIN) q = OUT_MIN;
         n++;
         ph = ph + cfg_down;
         r.smp = q[15:0];
         r.ch = ch;
         r.last = !(ph < cfg_up && n < RESULT_CAP);
         pending_outputs.push_back(r);
      end
      phase_shadow[ch] = ph[6:0];
   endfunction

   function automatic logic [15:0] rand_word();
      logic signed [15:0] w;
      w = $urandom;
      return w >>> $urandom_range(0, 9);
   endfunction

   task automatic push_item(input req_item_t it);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.func;
      req_tdata  <= {4'b0, it.smp, it.val, it.idx, it.ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (it.func == FUNC_COEF) begin
         if (it.idx < TABLE_WORDS) coef_shadow[it.idx] = it.val;
      end else begin
         resample_predict(it.ch, it.smp);
      end
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_UP_FACTOR:   cfg_up = val;
         CSR_DOWN_FACTOR: cfg_down = val;
         CSR_LONG_FILTER: cfg_long = val[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic wait_drain();
      while (pending_outputs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic note_error(input string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outputs.size() == 0) begin
            note_error($sformatf("unexpected item smp %0d ch %0d last %0d",
                                 $signed(rsp_tdata[15:0]), rsp_tdata[16], rsp_tlast));
         end else begin
            head_item = pending_outputs.pop_front();
            if (rsp_tdata[15:0] !== head_item.smp || rsp_tdata[16] !== head_item.ch ||
                rsp_tlast !== head_item.last)
               note_error($sformatf("expected smp %0d ch %0d last %0d, got smp %0d ch %0d last %0d",
                                    head_item.smp, head_item.ch, head_item.last,
                                    $signed(rsp_tdata[15:0]), rsp_tdata[16], rsp_tlast));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      req_item_t it;
      out_item_t r;
      phase_t    p;
      for (int c = 0; c < CHANNELS_DEF; c++) begin
         phase_shadow[c] = '0;
         for (int t = 0; t < MAX_TAPS_DEF; t++) line_shadow[c][t] = '0;
      end
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill the whole table, first branch zeroed for the directed rows
      for (int i = 0; i < TABLE_WORDS; i++) begin
         it.func = FUNC_COEF;
         it.ch   = $urandom;
         it.idx  = i;
         it.val  = (i < MAX_TAPS_DEF) ? 16'h0000 : rand_word();
         it.smp  = $urandom;
         push_item(it);
      end

      foreach (dir_tab[i]) begin
         it.func = dir_tab[i].func;
         it.ch   = dir_tab[i].ch;
         it.idx  = dir_tab[i].idx;
         it.val  = dir_tab[i].val;
         it.smp  = dir_tab[i].smp;
         push_item(it);
         if (dir_tab[i].chk) begin
            r = pending_outputs.pop_back();
            r.smp = dir_tab[i].exp_smp;
            pending_outputs.push_back(r);
         end
      end

      foreach (phase_tab[k]) begin
         p = phase_tab[k];
         req_tvalid <= 1'b0;
         wait_drain();
         idle_pct  = p.idle;
         stall_pct = p.stall;
         write_csr(CSR_UP_FACTOR, (p.up == 0) ? 7'($urandom_range(1, 8)) : p.up);
         write_csr(CSR_DOWN_FACTOR, (p.down == 0) ? 7'($urandom_range(1, 8)) : p.down);
         write_csr(CSR_LONG_FILTER, (p.long_sel > 1) ? 7'($urandom_range(0, 1)) : 7'(p.long_sel));
         csr_valid <= 1'b0;
         for (int n = 0; n < p.count; n++) begin
            it.func = ($urandom_range(0, 99) < 15) ? FUNC_COEF : FUNC_SAMPLE;
            it.ch   = $urandom;
            it.idx  = ($urandom_range(0, 99) < 30) ? 11'($urandom_range(0, MAX_TAPS_DEF - 1))
                                                   : 11'($urandom);
            it.val  = rand_word();
            it.smp  = rand_word();
            push_item(it);
         end
      end

      req_tvalid <= 1'b0;
      wait_drain();
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/rpr_pkg.sv
rtl/rpr_tap_cell.sv
rtl/rpr_delay_chain.sv
rtl/rpr_mac.sv
rtl/polyphase_rational_resampler.sv
rtl/rpr_checker.sv
tb/tb.sv
